[rtl/cosine_ridge_mountain_height_unit_defines.svh]
// ---------------------------------------------------------------------------
// Cosine ridge mountain height unit: assertion macros
// Shared property macros for the height unit, empty for synthesis.
// ---------------------------------------------------------------------------
`ifndef COSINE_RIDGE_MOUNTAIN_HEIGHT_UNIT_DEFINES_SVH
`define COSINE_RIDGE_MOUNTAIN_HEIGHT_UNIT_DEFINES_SVH

`ifndef SYNTHESIS
// same-cycle implication
`define CRMH_ASSERT_IMP(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("height unit check failed");
// next-cycle implication
`define CRMH_ASSERT_NXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("height unit check failed");
`else
`define CRMH_ASSERT_IMP(lbl, clk, rst, ante, cons)
`define CRMH_ASSERT_NXT(lbl, clk, rst, ante, cons)
`endif

`endif

[rtl/crmh_pkg.sv]
// ---------------------------------------------------------------------------
// crmh_pkg
// Types, widths and constants shared by the mountain height pipeline.
// ---------------------------------------------------------------------------
`default_nettype none
package crmh_pkg;

   localparam int COMPONENT_BITS = 16;
   localparam int IN_W    = ((3 * COMPONENT_BITS + 7) / 8) * 8;
   localparam int SUM_W   = 2 * COMPONENT_BITS;
   localparam int ROOT_W  = COMPONENT_BITS;
   localparam int REM_W   = ROOT_W + 3;
   localparam int SCALE_SHIFT = 24;
   localparam int CW      = COMPONENT_BITS + 28;   // vectoring datapath
   localparam int ANG_W   = 28;                    // signed angle accumulator
   localparam int T_W     = 25;                    // angle 0..pi, pi = 2^24
   localparam int Q_W     = 33;                    // rotation datapath
   localparam int COS_W   = 32;
   localparam int CORDIC_STEPS = 24;

   localparam int HEIGHT_W = 15;
   localparam int GEO_W    = 23;
   localparam int GRAV_W   = 16;
   localparam int OUT_W    = 40;

   localparam logic [T_W-1:0] ANG_PI       = T_W'(24'hFFFFFF) + T_W'(1);
   localparam logic [T_W-1:0] ANG_HALF_PI  = T_W'(23'h400000) << 1;
   localparam logic [T_W-1:0] RIDGE_LIMIT  = T_W'(12582912);
   localparam logic [26:0]    RECIP_3      = 27'd89478486;   // ceil(2^28/3)
   localparam logic signed [Q_W-1:0] INV_GAIN = Q_W'(652032874);
   localparam logic signed [Q_W-1:0] Q30_ONE  = Q_W'(1073741824);
   localparam logic [14:0]    PEAK_HEIGHT  = 15'd32000;
   localparam logic [GRAV_W-1:0] GRAVITY_RESET = 16'd2510;

   // configuration register indexes
   localparam logic REG_TERRAIN_MODE = 1'b0;
   localparam logic REG_GRAVITY      = 1'b1;

   typedef struct packed {
      logic                         valid;
      logic                         mode;
      logic                         zero;
      logic                         ridge;
      logic signed [COMPONENT_BITS:0] neg_y;
   } side_type;

   // arctan(2^-i), pi = 2^24
   function automatic logic [ANG_W-1:0] arc_angle(input int i);
      logic [ANG_W-1:0] a;
      case (i)
         0: a = 28'd4194304;   1: a = 28'd2476042;   2: a = 28'd1308273;
         3: a = 28'd664100;    4: a = 28'd333339;    5: a = 28'd166832;
         6: a = 28'd83436;     7: a = 28'd41721;     8: a = 28'd20861;
         9: a = 28'd10430;     10: a = 28'd5215;     11: a = 28'd2608;
         12: a = 28'd1304;     13: a = 28'd652;      14: a = 28'd326;
         15: a = 28'd163;      16: a = 28'd81;       17: a = 28'd41;
         18: a = 28'd20;       19: a = 28'd10;       20: a = 28'd5;
         21: a = 28'd3;        22: a = 28'd1;        23: a = 28'd1;
         default: a = '0;
      endcase
      return a;
   endfunction

endpackage
`default_nettype wire

[rtl/crmh_sqrt.sv]
// ---------------------------------------------------------------------------
// crmh_sqrt
// Pipelined floor square root, one result bit per stage.
// ---------------------------------------------------------------------------
`default_nettype none
module crmh_sqrt (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       en,
   input  wire logic [crmh_pkg::SUM_W-1:0] rad_i,
   input  wire crmh_pkg::side_type         side_i,
   output logic [crmh_pkg::ROOT_W-1:0]     root_o,
   output crmh_pkg::side_type              side_o
);
   import crmh_pkg::*;

   logic [SUM_W-1:0]  rad_ff  [0:ROOT_W];
   logic [REM_W-1:0]  rem_ff  [0:ROOT_W];
   logic [ROOT_W-1:0] root_ff [0:ROOT_W];
   side_type          side_ff [0:ROOT_W];

   // entry stage
   always_ff @(posedge clock) begin
      if (en) begin
         rad_ff[0]  <= rad_i;
         rem_ff[0]  <= '0;
         root_ff[0] <= '0;
      end
      if (reset) begin
         side_ff[0] <= '0;
      end else if (en) begin
         side_ff[0] <= side_i;
      end
   end

   // one root bit per stage
   for (genvar j = 0; j < ROOT_W; j++) begin : g_bit
      logic [REM_W-1:0] rem_in, trial_in;
      always_comb begin
         rem_in   = {rem_ff[j][REM_W-3:0], rad_ff[j][SUM_W-1 -: 2]};
         trial_in = {1'b0, root_ff[j], 2'b01};
      end
      always_ff @(posedge clock) begin
         if (en) begin
            rad_ff[j+1] <= rad_ff[j] << 2;
            if (rem_in >= trial_in) begin
               rem_ff[j+1]  <= rem_in - trial_in;
               root_ff[j+1] <= {root_ff[j][ROOT_W-2:0], 1'b1};
            end else begin
               rem_ff[j+1]  <= rem_in;
               root_ff[j+1] <= {root_ff[j][ROOT_W-2:0], 1'b0};
            end
         end
         if (reset) begin
            side_ff[j+1] <= '0;
         end else if (en) begin
            side_ff[j+1] <= side_ff[j];
         end
      end
   end

   assign root_o = root_ff[ROOT_W];
   assign side_o = side_ff[ROOT_W];

endmodule
`default_nettype wire

[rtl/crmh_vec.sv]
// ---------------------------------------------------------------------------
// crmh_vec
// Pipelined vectoring CORDIC: angle of (-y, s) in binary radians.
// ---------------------------------------------------------------------------
`default_nettype none
module crmh_vec (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        en,
   input  wire logic [crmh_pkg::ROOT_W-1:0] s_i,
   input  wire crmh_pkg::side_type          side_i,
   output logic signed [crmh_pkg::ANG_W-1:0] acc_o,
   output crmh_pkg::side_type               side_o
);
   import crmh_pkg::*;

   logic signed [CW-1:0]    px_ff  [0:CORDIC_STEPS];
   logic signed [CW-1:0]    py_ff  [0:CORDIC_STEPS];
   logic signed [ANG_W-1:0] acc_ff [0:CORDIC_STEPS];
   side_type                side_ff [0:CORDIC_STEPS];

   logic signed [CW-1:0] cs, ss;

   // scale both legs by 2^24
   always_comb begin
      cs = {{(CW-COMPONENT_BITS-1-SCALE_SHIFT){side_i.neg_y[COMPONENT_BITS]}},
            side_i.neg_y, {SCALE_SHIFT{1'b0}}};
      ss = {{(CW-ROOT_W-SCALE_SHIFT){1'b0}}, s_i, {SCALE_SHIFT{1'b0}}};
   end

   // pre-rotation by -pi/2 when the cosine leg is negative
   always_ff @(posedge clock) begin
      if (en) begin
         if (cs < 0) begin
            px_ff[0]  <= ss;
            py_ff[0]  <= -cs;
            acc_ff[0] <= ANG_W'(ANG_HALF_PI);
         end else begin
            px_ff[0]  <= cs;
            py_ff[0]  <= ss;
            acc_ff[0] <= '0;
         end
      end
      if (reset) begin
         side_ff[0] <= '0;
      end else if (en) begin
         side_ff[0] <= side_i;
      end
   end

   for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_step
      always_ff @(posedge clock) begin
         if (en) begin
            if (py_ff[i] > 0) begin
               px_ff[i+1]  <= px_ff[i] + (py_ff[i] >>> i);
               py_ff[i+1]  <= py_ff[i] - (px_ff[i] >>> i);
               acc_ff[i+1] <= acc_ff[i] + $signed(arc_angle(i));
            end else begin
               px_ff[i+1]  <= px_ff[i] - (py_ff[i] >>> i);
               py_ff[i+1]  <= py_ff[i] + (px_ff[i] >>> i);
               acc_ff[i+1] <= acc_ff[i] - $signed(arc_angle(i));
            end
         end
         if (reset) begin
            side_ff[i+1] <= '0;
         end else if (en) begin
            side_ff[i+1] <= side_ff[i];
         end
      end
   end

   assign acc_o  = acc_ff[CORDIC_STEPS];
   assign side_o = side_ff[CORDIC_STEPS];

endmodule
`default_nettype wire

[rtl/crmh_cos.sv]
// ---------------------------------------------------------------------------
// crmh_cos
// Two-lane pipelined rotation CORDIC giving cos in Q30 for angles 0..pi.
// ---------------------------------------------------------------------------
`default_nettype none
module crmh_cos (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          en,
   input  wire logic [crmh_pkg::T_W-1:0]      t1_i,
   input  wire logic [crmh_pkg::T_W-1:0]      t2_i,
   input  wire crmh_pkg::side_type            side_i,
   output logic signed [crmh_pkg::COS_W-1:0]  c1_o,
   output logic signed [crmh_pkg::COS_W-1:0]  c2_o,
   output crmh_pkg::side_type                 side_o
);
   import crmh_pkg::*;

   side_type side_ff [0:CORDIC_STEPS+1];
   logic signed [COS_W-1:0] cos_lane [0:1];

   // sideband follows the lanes, one extra stage for the output clamp
   always_ff @(posedge clock) begin
      if (reset) begin
         side_ff[0] <= '0;
      end else if (en) begin
         side_ff[0] <= side_i;
      end
   end
   for (genvar k = 0; k <= CORDIC_STEPS; k++) begin : g_side
      always_ff @(posedge clock) begin
         if (reset) begin
            side_ff[k+1] <= '0;
         end else if (en) begin
            side_ff[k+1] <= side_ff[k];
         end
      end
   end

   for (genvar l = 0; l < 2; l++) begin : g_lane
      logic signed [Q_W-1:0]   cx_ff   [0:CORDIC_STEPS];
      logic signed [Q_W-1:0]   cy_ff   [0:CORDIC_STEPS];
      logic signed [ANG_W-1:0] rest_ff [0:CORDIC_STEPS];
      logic                    flip_ff [0:CORDIC_STEPS];
      logic signed [COS_W-1:0] cos_ff;
      logic [T_W-1:0]          t;
      logic signed [Q_W-1:0]   cx_clamp;

      assign t = (l == 0) ? t1_i : t2_i;

      // fold into the first quadrant
      always_ff @(posedge clock) begin
         if (en) begin
            cx_ff[0] <= INV_GAIN;
            cy_ff[0] <= '0;
            if (t > ANG_HALF_PI) begin
               rest_ff[0] <= ANG_W'(ANG_PI - t);
               flip_ff[0] <= 1'b1;
            end else begin
               rest_ff[0] <= ANG_W'(t);
               flip_ff[0] <= 1'b0;
            end
         end
      end

      for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_step
         always_ff @(posedge clock) begin
            if (en) begin
               flip_ff[i+1] <= flip_ff[i];
               if (rest_ff[i] >= 0) begin
                  cx_ff[i+1]   <= cx_ff[i] - (cy_ff[i] >>> i);
                  cy_ff[i+1]   <= cy_ff[i] + (cx_ff[i] >>> i);
                  rest_ff[i+1] <= rest_ff[i] - $signed(arc_angle(i));
               end else begin
                  cx_ff[i+1]   <= cx_ff[i] + (cy_ff[i] >>> i);
                  cy_ff[i+1]   <= cy_ff[i] - (cx_ff[i] >>> i);
                  rest_ff[i+1] <= rest_ff[i] + $signed(arc_angle(i));
               end
            end
         end
      end

      // clamp to [0, 1] then restore the sign
      always_comb begin
         cx_clamp = cx_ff[CORDIC_STEPS];
         if (cx_clamp < 0) begin
            cx_clamp = '0;
         end else if (cx_clamp > Q30_ONE) begin
            cx_clamp = Q30_ONE;
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            cos_ff <= flip_ff[CORDIC_STEPS] ? -COS_W'(cx_clamp) : COS_W'(cx_clamp);
         end
      end

      assign cos_lane[l] = cos_ff;
   end

   assign c1_o   = cos_lane[0];
   assign c2_o   = cos_lane[1];
   assign side_o = side_ff[CORDIC_STEPS+1];

endmodule
`default_nettype wire

[rtl/cosine_ridge_mountain_height_unit.sv]
// ---------------------------------------------------------------------------
// cosine_ridge_mountain_height_unit
// Cosine ridge mountain height and geopotential for one cell direction.
// ---------------------------------------------------------------------------
// Usage:
//   req_ channel carries one cell-centre direction (x, y, z) per request.
//   rsp_ channel returns height, geopotential and a zero-vector status
//   flag for each request, in order.
//   csr_ port sets terrain mode (index 0) and gravity (index 1); write
//   only while no request is in flight.
// Pipeline: input and square stages (3), root pipeline (17), vectoring
//   CORDIC (25), angle stages (2), cosine CORDIC (26), product stages (6)
//   and the output register.
// Throughput: one request per cycle while the result side does not stall;
//   the depth of the two CORDIC units and the root sets most of the latency.
// Reset: every stage is emptied, terrain mode goes to mountain and gravity
//   to 2510/256 m/s^2.
// Stall: while a result waits with rsp_tready low the whole pipeline holds
//   and req_tready falls; nothing is lost or repeated.
// ---------------------------------------------------------------------------
`default_nettype none
`include "cosine_ridge_mountain_height_unit_defines.svh"
module cosine_ridge_mountain_height_unit (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          req_tvalid,
   output logic                               req_tready,
   input  wire logic [crmh_pkg::IN_W-1:0]     req_tdata,  // pos_x, pos_y, pos_z
   output logic                               rsp_tvalid,
   input  wire logic                          rsp_tready,
   output logic [crmh_pkg::OUT_W-1:0]         rsp_tdata,  // height, geopotential, status
   input  wire logic                          csr_we,
   input  wire logic                          csr_addr,
   input  wire logic [crmh_pkg::GRAV_W-1:0]   csr_wdata
);
   import crmh_pkg::*;

   localparam int CB = COMPONENT_BITS;

   logic en;

   // configuration registers
   logic              terrain_mode_ff;
   logic [GRAV_W-1:0] gravity_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         terrain_mode_ff <= 1'b1;
         gravity_ff      <= GRAVITY_RESET;
      end else if (csr_we) begin
         unique case (csr_addr)
            REG_TERRAIN_MODE: terrain_mode_ff <= csr_wdata[0];
            REG_GRAVITY:      gravity_ff      <= csr_wdata;
            default: ;
         endcase
      end
   end

   // whole pipeline moves when the output register is free
   logic rsp_valid_ff;
   assign en         = !rsp_valid_ff || rsp_tready;
   assign req_tready = en;

   // stage 0: capture request
   logic signed [CB-1:0] x_ff, y_ff, z_ff;
   side_type             s0_ff, s0_in;
   always_comb begin
      s0_in       = '0;
      s0_in.valid = req_tvalid;
      s0_in.mode  = terrain_mode_ff;
   end
   always_ff @(posedge clock) begin
      if (en) begin
         x_ff <= req_tdata[CB-1:0];
         y_ff <= req_tdata[2*CB-1:CB];
         z_ff <= req_tdata[3*CB-1:2*CB];
      end
      if (reset) begin
         s0_ff <= '0;
      end else if (en) begin
         s0_ff <= s0_in;
      end
   end

   // stage 1: squares of the horizontal legs
   logic [CB-1:0]    ax, az;
   logic [SUM_W-1:0] sqx_ff, sqz_ff;
   side_type         s1_ff, s1_in;
   assign ax = x_ff[CB-1] ? CB'(-x_ff) : CB'(x_ff);
   assign az = z_ff[CB-1] ? CB'(-z_ff) : CB'(z_ff);
   always_comb begin
      s1_in       = s0_ff;
      s1_in.zero  = (x_ff == '0) && (y_ff == '0) && (z_ff == '0);
      s1_in.neg_y = -{y_ff[CB-1], y_ff};
   end
   always_ff @(posedge clock) begin
      if (en) begin
         sqx_ff <= ax * ax;
         sqz_ff <= az * az;
      end
      if (reset) begin
         s1_ff <= '0;
      end else if (en) begin
         s1_ff <= s1_in;
      end
   end

   // stage 2: radicand
   logic [SUM_W-1:0] sum_ff;
   side_type         s2_ff;
   always_ff @(posedge clock) begin
      if (en) begin
         sum_ff <= sqx_ff + sqz_ff;
      end
      if (reset) begin
         s2_ff <= '0;
      end else if (en) begin
         s2_ff <= s1_ff;
      end
   end

   // root and angle
   logic [ROOT_W-1:0]       root;
   side_type                sr_side, sv_side;
   logic signed [ANG_W-1:0] acc;

   crmh_sqrt u_sqrt (
      .clock  (clock),
      .reset  (reset),
      .en     (en),
      .rad_i  (sum_ff),
      .side_i (s2_ff),
      .root_o (root),
      .side_o (sr_side)
   );

   crmh_vec u_vec (
      .clock  (clock),
      .reset  (reset),
      .en     (en),
      .s_i    (root),
      .side_i (sr_side),
      .acc_o  (acc),
      .side_o (sv_side)
   );

   // angle clamp to [0, pi]
   logic [T_W-1:0] d_ff;
   side_type       sd_ff;
   always_ff @(posedge clock) begin
      if (en) begin
         if (acc < 0) begin
            d_ff <= '0;
         end else if (acc > $signed(ANG_W'(ANG_PI))) begin
            d_ff <= ANG_PI;
         end else begin
            d_ff <= T_W'(acc);
         end
      end
      if (reset) begin
         sd_ff <= '0;
      end else if (en) begin
         sd_ff <= sv_side;
      end
   end

   // envelope angle 4d/3 by reciprocal, ridge angle 16d folded
   logic [53:0]    m3_ff;
   logic [T_W-1:0] t2_ff, t2_raw;
   side_type       sm_ff, sm_in;
   assign t2_raw = {d_ff[T_W-5:0], 4'b0};
   always_comb begin
      sm_in       = sd_ff;
      sm_in.ridge = d_ff < RIDGE_LIMIT;
   end
   always_ff @(posedge clock) begin
      if (en) begin
         m3_ff <= {d_ff, 2'b00} * RECIP_3;
         t2_ff <= (t2_raw > ANG_PI) ? T_W'(-t2_raw) : t2_raw;
      end
      if (reset) begin
         sm_ff <= '0;
      end else if (en) begin
         sm_ff <= sm_in;
      end
   end

   logic signed [COS_W-1:0] c1, c2;
   side_type                sc_side;

   crmh_cos u_cos (
      .clock  (clock),
      .reset  (reset),
      .en     (en),
      .t1_i   (m3_ff[28 +: T_W]),
      .t2_i   (t2_ff),
      .side_i (sm_ff),
      .c1_o   (c1),
      .c2_o   (c2),
      .side_o (sc_side)
   );

   // envelope and ridge magnitude
   logic [30:0] env_ff, ac2_ff;
   logic [COS_W-1:0] env_sum;
   side_type    se_ff;
   assign env_sum = COS_W'(Q30_ONE) + c1;
   always_ff @(posedge clock) begin
      if (en) begin
         env_ff <= env_sum[31:1];
         ac2_ff <= c2[COS_W-1] ? 31'(-c2) : 31'(c2);
      end
      if (reset) begin
         se_ff <= '0;
      end else if (en) begin
         se_ff <= sc_side;
      end
   end

   // ridge factor squared
   logic [61:0] sq2_ff;
   logic [30:0] env2_ff;
   side_type    sq_ff;
   always_ff @(posedge clock) begin
      if (en) begin
         sq2_ff  <= ac2_ff * ac2_ff;
         env2_ff <= env_ff;
      end
      if (reset) begin
         sq_ff <= '0;
      end else if (en) begin
         sq_ff <= se_ff;
      end
   end

   // envelope times ridge factor
   logic [61:0] rid_sum, pm_ff;
   side_type    sp_ff;
   assign rid_sum = sq2_ff + 62'(1 << 29);
   always_ff @(posedge clock) begin
      if (en) begin
         pm_ff <= env2_ff * rid_sum[60:30];
      end
      if (reset) begin
         sp_ff <= '0;
      end else if (en) begin
         sp_ff <= sq_ff;
      end
   end

   // scale to peak height
   logic [61:0] prod_sum;
   logic [45:0] hm_ff;
   side_type    sh_ff;
   assign prod_sum = pm_ff + 62'(1 << 29);
   always_ff @(posedge clock) begin
      if (en) begin
         hm_ff <= prod_sum[60:30] * PEAK_HEIGHT;
      end
      if (reset) begin
         sh_ff <= '0;
      end else if (en) begin
         sh_ff <= sp_ff;
      end
   end

   // round, cap and apply the special cases
   logic [45:0]         hm_sum;
   logic [15:0]         h_raw;
   logic [HEIGHT_W-1:0] h_ff;
   logic                st_ff, hv_ff;
   assign hm_sum = hm_ff + 46'(1 << 29);
   assign h_raw  = hm_sum[45:30];
   always_ff @(posedge clock) begin
      if (en) begin
         if (!sh_ff.mode || sh_ff.zero || !sh_ff.ridge) begin
            h_ff <= '0;
         end else if (h_raw > 16'(PEAK_HEIGHT)) begin
            h_ff <= PEAK_HEIGHT;
         end else begin
            h_ff <= h_raw[HEIGHT_W-1:0];
         end
         st_ff <= sh_ff.mode && sh_ff.zero;
      end
      if (reset) begin
         hv_ff <= 1'b0;
      end else if (en) begin
         hv_ff <= sh_ff.valid;
      end
   end

   // gravity product
   logic [30:0]         gm_ff;
   logic [HEIGHT_W-1:0] h2_ff;
   logic                st2_ff, gv_ff;
   always_ff @(posedge clock) begin
      if (en) begin
         gm_ff  <= h_ff * gravity_ff;
         h2_ff  <= h_ff;
         st2_ff <= st_ff;
      end
      if (reset) begin
         gv_ff <= 1'b0;
      end else if (en) begin
         gv_ff <= hv_ff;
      end
   end

   // output register
   logic [31:0]         gm_sum;
   logic [HEIGHT_W-1:0] height_ff;
   logic [GEO_W-1:0]    geo_ff;
   logic                status_ff;
   assign gm_sum = {1'b0, gm_ff} + 32'd128;
   always_ff @(posedge clock) begin
      if (en) begin
         height_ff <= h2_ff;
         geo_ff    <= gm_sum[GEO_W+7:8];
         status_ff <= st2_ff;
      end
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (en) begin
         rsp_valid_ff <= gv_ff;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{(OUT_W-HEIGHT_W-GEO_W-1){1'b0}}, status_ff, geo_ff, height_ff};

   // checks
   `CRMH_ASSERT_IMP(a_status_zero, clock, reset, rsp_valid_ff && status_ff, height_ff == '0 && geo_ff == '0)
   `CRMH_ASSERT_IMP(a_height_cap, clock, reset, rsp_valid_ff, height_ff <= PEAK_HEIGHT)
   `CRMH_ASSERT_NXT(a_hold_stall, clock, reset, rsp_valid_ff && !rsp_tready, rsp_valid_ff && $stable(height_ff) && $stable(geo_ff))

endmodule
`default_nettype wire

[tb/tb_cosine_ridge_mountain_height_unit.sv]
// ---------------------------------------------------------------------------
// Testbench for the cosine ridge mountain height unit
// Drives cell directions in directed and random phases under several
// terrain mode and gravity settings. Each result is checked against a
// height predictor or an expected value given in the row, with random gaps
// on the request side and random back-pressure on the result side.
// ---------------------------------------------------------------------------
module tb_cosine_ridge_mountain_height_unit;
   timeunit 1ns;
   timeprecision 1ps;

   import crmh_pkg::*;

   localparam int CB       = COMPONENT_BITS;
   localparam int N_PHASES = 8;
   localparam int PHASE_N  = 210;
   localparam int DRAIN    = 100;   // a little over the pipeline latency

   // packed from the top down: height sits in the lowest bits
   typedef struct packed {
      logic                status;
      logic [GEO_W-1:0]    geo;
      logic [HEIGHT_W-1:0] height;
   } mtn_result_t;

   typedef struct {
      logic              mode;
      logic [GRAV_W-1:0] grav;
      logic [CB-1:0]     px, py, pz;
      bit                typed;   // expected result given in the row
      mtn_result_t       res;
   } dir_row_t;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               req_tvalid = 1'b0;
   logic               req_tready;
   logic [IN_W-1:0]    req_tdata = '0;
   logic               rsp_tvalid;
   logic               rsp_tready = 1'b0;
   logic [OUT_W-1:0]   rsp_tdata;
   logic               csr_we = 1'b0;
   logic               csr_addr = REG_TERRAIN_MODE;
   logic [GRAV_W-1:0]  csr_wdata = '0;

   // predictor copy of the registers
   logic               mdl_mode = 1'b1;
   logic [GRAV_W-1:0]  mdl_grav = GRAVITY_RESET;
   bit                 no_gaps;
   int                 fail_count = 0;
   mtn_result_t        height_queue[$];
   dir_row_t           dir_rows[$];

   cosine_ridge_mountain_height_unit DUT (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata),
      .csr_we(csr_we), .csr_addr(csr_addr), .csr_wdata(csr_wdata)
   );

   initial begin
      forever #6 clock = ~clock;
   end

   initial begin
      #20ms;
      $display("Some tests failed");
      $finish;
   end

   // ---- predictor -------------------------------------------------------
   const longint arctan_b[CORDIC_STEPS] = '{
      4194304, 2476042, 1308273, 664100, 333339, 166832, 83436, 41721,
      20861, 10430, 5215, 2608, 1304, 652, 326, 163,
      81, 41, 20, 10, 5, 3, 1, 1};

   function automatic longint isqrt(longint unsigned n);
      longint unsigned r = 0, b = 64'd1 << 62;
      while (b > n) b >>= 2;
      while (b != 0) begin
         if (n >= r + b) begin
            n -= r + b;
            r = (r >> 1) + b;
         end else begin
            r >>= 1;
         end
         b >>= 2;
      end
      return longint'(r);
   endfunction

   // great-circle angle of (c, s), s >= 0; arithmetic shifts floor
   function automatic longint ridge_angle(longint c, longint s);
      longint vx, vy, acc = 0, dx, dy;
      if (c < 0) begin
         vx = s; vy = -c; acc = 64'sd8388608;
      end else begin
         vx = c; vy = s;
      end
      for (int i = 0; i < CORDIC_STEPS; i++) begin
         dx = vy >>> i;
         dy = vx >>> i;
         if (vy > 0) begin
            vx += dx; vy -= dy; acc += arctan_b[i];
         end else begin
            vx -= dx; vy += dy; acc -= arctan_b[i];
         end
      end
      if (acc < 0) acc = 0;
      if (acc > 64'sd16777216) acc = 64'sd16777216;
      return acc;
   endfunction

   function automatic longint cos_q30(longint t);
      bit     flip = 0;
      longint cx = 652032874, cy = 0, rest, dx, dy;
      if (t > 64'sd8388608) begin
         t = 64'sd16777216 - t;
         flip = 1;
      end
      rest = t;
      for (int i = 0; i < CORDIC_STEPS; i++) begin
         dx = cy >>> i;
         dy = cx >>> i;
         if (rest >= 0) begin
            cx -= dx; cy += dy; rest -= arctan_b[i];
         end else begin
            cx += dx; cy -= dy; rest += arctan_b[i];
         end
      end
      if (cx < 0) cx = 0;
      if (cx > 64'sd1073741824) cx = 64'sd1073741824;
      return flip ? -cx : cx;
   endfunction

   function automatic mtn_result_t predict_height(logic [CB-1:0] px, logic [CB-1:0] py,
                                                  logic [CB-1:0] pz);
      mtn_result_t     r;
      longint          x, y, z, s, d, t1, t2, c1, c2;
      longint unsigned ax, az, h = 0, env, rid, prod, ac2;
      x = longint'(signed'(px));
      y = longint'(signed'(py));
      z = longint'(signed'(pz));
      r.status = 1'b0;
      if (mdl_mode) begin
         if (x == 0 && y == 0 && z == 0) begin
            r.status = 1'b1;
         end else begin
            ax = (x < 0) ? -x : x;
            az = (z < 0) ? -z : z;
            s  = isqrt(ax * ax + az * az);
            d  = ridge_angle(-y * (64'sd1 << 24), s * (64'sd1 << 24));
            if (d < 64'sd12582912) begin
               t1 = (4 * d) / 3;
               t2 = (16 * d) & ((64'sd1 << 25) - 1);
               if (t2 > 64'sd16777216) t2 = (64'sd1 << 25) - t2;
               c1   = cos_q30(t1);
               c2   = cos_q30(t2);
               ac2  = (c2 < 0) ? -c2 : c2;
               env  = longint'(64'sd1073741824 + c1) >> 1;
               rid  = (ac2 * ac2 + (64'd1 << 29)) >> 30;
               prod = (env * rid + (64'd1 << 29)) >> 30;
               h    = (64'd32000 * prod + (64'd1 << 29)) >> 30;
               if (h > 32000) h = 32000;
            end
         end
      end
      r.height = h[HEIGHT_W-1:0];
      r.geo    = GEO_W'((h * mdl_grav + 128) >> 8);
      return r;
   endfunction

   // ---- stimulus helpers ------------------------------------------------
   function automatic int pick_gap();
      int r;
      if (no_gaps) return 0;
      r = $urandom_range(0, 99);
      if (r < 60) return 0;
      if (r < 90) return $urandom_range(1, 3);
      if (r < 98) return $urandom_range(4, 10);
      return $urandom_range(20, 60);
   endfunction

   // one request; returns at the falling edge after acceptance
   task automatic send_cell(logic [CB-1:0] px, logic [CB-1:0] py, logic [CB-1:0] pz);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= IN_W'({pz, py, px});
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      height_queue.push_back(predict_height(px, py, pz));
      @(negedge clock);
   endtask

   // wait for idle, then write both registers
   task automatic set_terrain(logic mode, logic [GRAV_W-1:0] grav);
      req_tvalid <= 1'b0;
      while (height_queue.size() != 0) @(negedge clock);
      repeat (DRAIN) @(negedge clock);
      csr_we <= 1'b1; csr_addr <= REG_TERRAIN_MODE; csr_wdata <= GRAV_W'(mode);
      @(negedge clock);
      csr_addr <= REG_GRAVITY; csr_wdata <= grav;
      @(negedge clock);
      csr_we <= 1'b0;
      mdl_mode = mode;
      mdl_grav = grav;
   endtask

   function automatic void add_row(logic mode, logic [GRAV_W-1:0] grav, int x, int y, int z,
                                   bit typed = 0, int h = 0, int g = 0, bit st = 0);
      dir_row_t row;
      row.mode = mode; row.grav = grav;
      row.px = CB'(x); row.py = CB'(y); row.pz = CB'(z);
      row.typed = typed;
      row.res.height = HEIGHT_W'(h); row.res.geo = GEO_W'(g); row.res.status = st;
      dir_rows.push_back(row);
   endfunction

   // ---- result checker --------------------------------------------------
   always @(posedge clock) begin
      mtn_result_t got, want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = rsp_tdata[HEIGHT_W+GEO_W:0];
         if (height_queue.size() == 0) begin
            fail_count++;
            if (fail_count < 60)
               $display("%0t: unexpected result, actual %h", $realtime, got);
         end else begin
            want = height_queue.pop_front();
            if (got.height !== want.height || got.geo !== want.geo ||
                got.status !== want.status || rsp_tdata[OUT_W-1] !== 1'b0) begin
               fail_count++;
               if (fail_count < 60)
                  $display("%0t: mismatch, expected h=%0d g=%0d st=%0d actual h=%0d g=%0d st=%0d",
                           $realtime, want.height, want.geo, want.status,
                           got.height, got.geo, got.status);
            end
         end
      end
   end

   // ---- result back-pressure --------------------------------------------
   initial begin
      int run;
      @(negedge clock);
      forever begin
         run = ($urandom_range(0, 9) == 0) ? $urandom_range(100, 400) : $urandom_range(1, 20);
         rsp_tready <= 1'b1;
         repeat (run) @(negedge clock);
         rsp_tready <= 1'b0;
         repeat (pick_gap() + 1) @(negedge clock);
      end
   end

   // ---- main sequence ---------------------------------------------------
   initial begin
      logic [CB-1:0]     px, py, pz;
      logic              cur_mode;
      logic [GRAV_W-1:0] cur_grav;
      logic              modes[N_PHASES];
      logic [GRAV_W-1:0] gravs[N_PHASES];
      int                k, sh;
      int                corner[5];

      corner = '{-32768, -1, 0, 1, 32767};
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed rows; the first group runs on the reset settings
      add_row(1, 2510, 0, 0, 0, 1, 0, 0, 1);             // zero vector
      add_row(1, 2510, 0, 32767, 0, 1, 0, 0, 0);         // antipode, outside ridge
      add_row(1, 2510, 0, 1, 0, 1, 0, 0, 0);
      add_row(1, 2510, 0, -32768, 0);                    // peak
      add_row(1, 2510, 0, -1, 0);
      add_row(1, 2510, 32767, 0, 0);
      add_row(1, 2510, -32768, 0, -32768);
      add_row(1, 2510, -32768, -32768, -32768);
      add_row(1, 2510, 32767, 32767, 32767);
      add_row(1, 2510, 32767, -32768, 32767);
      add_row(1, 2510, -1, -1, -1);
      add_row(1, 2510, 0, 0, 1);
      add_row(1, 2510, 100, 100, 0);                     // near ridge edge
      add_row(1, 65535, 0, -32768, 0);
      add_row(1, 65535, 0, 0, 0, 1, 0, 0, 1);
      add_row(1, 0, 0, -32768, 0);                       // gravity zero
      add_row(1, 1, 5, -20000, 0);
      add_row(0, 2510, 0, 0, 0, 1, 0, 0, 0);             // flat mode, no zero flag
      add_row(0, 2510, 0, -32768, 0, 1, 0, 0, 0);
      add_row(0, 65535, -32768, -32768, -32768, 1, 0, 0, 0);
      add_row(1, 2510, 0, 0, 0, 1, 0, 0, 1);

      cur_mode = 1'b1;
      cur_grav = GRAVITY_RESET;
      no_gaps  = 0;
      foreach (dir_rows[i]) begin
         if (dir_rows[i].mode !== cur_mode || dir_rows[i].grav !== cur_grav) begin
            set_terrain(dir_rows[i].mode, dir_rows[i].grav);
            cur_mode = dir_rows[i].mode;
            cur_grav = dir_rows[i].grav;
         end
         send_cell(dir_rows[i].px, dir_rows[i].py, dir_rows[i].pz);
         // typed rows override the predictor
         if (dir_rows[i].typed) begin
            void'(height_queue.pop_back());
            height_queue.push_back(dir_rows[i].res);
         end
      end

      // random phases
      modes = '{1, 1, 0, 1, 1, 0, 1, 1};
      gravs = '{2510, 65535, GRAV_W'($urandom), 1, GRAV_W'($urandom), 65535, 0,
                GRAV_W'($urandom_range(1, 65535))};
      for (int p = 0; p < N_PHASES; p++) begin
         set_terrain(modes[p], gravs[p]);
         no_gaps = (p == 3);
         for (int n = 0; n < PHASE_N; n++) begin
            k  = $urandom_range(0, 99);
            sh = $urandom_range(0, CB - 1);
            if (k < 70) begin
               // mostly inside the ridge: y negative, random scale
               px = CB'(signed'(CB'($urandom)) >>> sh);
               pz = CB'(signed'(CB'($urandom)) >>> sh);
               py = CB'(-($urandom_range(1, 32768) >> $urandom_range(0, CB - 2)));
               if (py == 0) py = CB'(-1);
            end else if (k < 90) begin
               px = CB'($urandom); py = CB'($urandom); pz = CB'($urandom);
            end else if (k < 94) begin
               px = '0; py = '0; pz = '0;
            end else begin
               px = CB'(corner[$urandom_range(0, 4)]);
               py = CB'(corner[$urandom_range(0, 4)]);
               pz = CB'(corner[$urandom_range(0, 4)]);
            end
            send_cell(px, py, pz);
         end
      end

      // drain
      req_tvalid <= 1'b0;
      while (height_queue.size() != 0) @(posedge clock);
      repeat (DRAIN) @(posedge clock);
      if (fail_count == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule

[sim.f]
+incdir+rtl
rtl/crmh_pkg.sv
rtl/crmh_sqrt.sv
rtl/crmh_vec.sv
rtl/crmh_cos.sv
rtl/cosine_ridge_mountain_height_unit.sv
tb/tb_cosine_ridge_mountain_height_unit.sv
